// File: rtl/core/kdte_pkg.sv
// ----------------------------------------------------------------------------
// kdte_pkg
// Shared types and constants for the key debounce and time entry block.
// ----------------------------------------------------------------------------
package kdte_pkg;

  typedef logic [1:0] key_event_t;

  localparam key_event_t KEY_NONE = 2'd0;
  localparam key_event_t KEY_DOWN = 2'd1;
  localparam key_event_t KEY_SET  = 2'd2;
  localparam key_event_t KEY_UP   = 2'd3;

  localparam int unsigned NUM_DIGITS = 6;

  localparam logic [3:0] DIGIT_BLANK = 4'd10;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [3:0] DIGIT_RESET = 4'd1;

  localparam logic [2:0] CURSOR_CONFIRM = 3'd6;

  localparam logic [7:0] DEBOUNCE_RESET = 8'd4;

  // Decimal place weights of the hhmmss digits
  localparam logic [20:0] W_HOUR_TENS = 21'd100000;
  localparam logic [20:0] W_HOUR_ONES = 21'd10000;
  localparam logic [20:0] W_MIN_TENS  = 21'd1000;
  localparam logic [20:0] W_MIN_ONES  = 21'd100;
  localparam logic [20:0] W_SEC_TENS  = 21'd10;

  // Queue status seen by both ends of the event queue
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/kdte_if.sv
// ----------------------------------------------------------------------------
// kdte_if
// Valid/ready channels for the key sample word and the result word.
// ----------------------------------------------------------------------------
interface kdte_in_if;
  logic valid;
  logic ready;
  logic key_down_n;
  logic key_set_n;
  logic key_up_n;

  modport source(output valid, key_down_n, key_set_n, key_up_n, input ready);
  modport sink(input valid, key_down_n, key_set_n, key_up_n, output ready);
endinterface

interface kdte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  key_event;
  logic        in_set_mode;
  logic [2:0]  cursor_pos;
  logic [3:0]  entry_digit;
  logic        commit_strobe;
  logic [18:0] commit_time;
  logic        reject_flag;

  modport source(output valid, key_event, in_set_mode, cursor_pos, entry_digit,
                 commit_strobe, commit_time, reject_flag, input ready);
  modport sink(input valid, key_event, in_set_mode, cursor_pos, entry_digit,
               commit_strobe, commit_time, reject_flag, output ready);
endinterface

// File: rtl/core/key_debounce_time_entry.sv
// ----------------------------------------------------------------------------
// key_debounce_time_entry
// Key debounce and six-digit hhmmss time entry with validated commit.
// ----------------------------------------------------------------------------
// One key sample word is taken per clock while the event queue is not full,
// and each yields exactly one result word; sustained rate is one word per
// cycle while the output is not stalled. The debounce stage classifies the
// sample into a key event and writes it to a short event queue (QUEUE_DEPTH
// entries); the entry stage drains one event per cycle into the output
// register while the output is free, so the input keeps flowing until the
// queue fills while the output is held. debounce_ticks may be written only
// while no word is in flight.
module key_debounce_time_entry
  import kdte_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  kdte_in_if.sink    in_ch,
  kdte_out_if.source out_ch
);

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  key_event_t push_event;
  key_event_t head_event;

  kdte_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push       (push),
    .push_event (push_event)
  );

  kdte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .pop        (pop),
    .head_event (head_event),
    .q_stat     (q_stat)
  );

  kdte_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .head_event (head_event),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/core/kdte_front.sv
// ----------------------------------------------------------------------------
// kdte_front
// Debounce stage: takes key samples, latches one key by priority and
// classifies each sample into a key event for the queue.
// ----------------------------------------------------------------------------
module kdte_front
  import kdte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  kdte_in_if.sink      in_ch,
  input  q_stat_t      q_stat,
  output logic         push,
  output key_event_t   push_event
);

  logic [7:0] debounce_ticks;
  logic [7:0] hold_count;
  logic [7:0] hold_count_next;
  logic       press_latched;
  logic       press_latched_next;
  key_event_t latched_key;
  key_event_t latched_key_next;
  logic [7:0] thr;
  logic       any_down;
  logic [7:0] hold_inc;

  assign in_ch.ready = ~q_stat.full;
  assign push        = in_ch.valid & ~q_stat.full;

  // a threshold of zero acts as one
  assign thr      = (debounce_ticks == 8'd0) ? 8'd1 : debounce_ticks;
  assign any_down = ~(in_ch.key_down_n & in_ch.key_set_n & in_ch.key_up_n);
  assign hold_inc = hold_count + 8'd1;

  always_comb begin
    hold_count_next    = hold_count;
    press_latched_next = press_latched;
    latched_key_next   = latched_key;
    push_event         = KEY_NONE;
    if (any_down) begin
      // saturate at the threshold; latch only on the tick it is reached
      if (hold_count < thr) begin
        hold_count_next = hold_inc;
        if (hold_inc == thr) begin
          press_latched_next = 1'b1;
          if (!in_ch.key_down_n)     latched_key_next = KEY_DOWN;
          else if (!in_ch.key_set_n) latched_key_next = KEY_SET;
          else                       latched_key_next = KEY_UP;
        end
      end
    end else begin
      hold_count_next = 8'd0;
      if (press_latched) begin
        press_latched_next = 1'b0;
        push_event         = latched_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      hold_count     <= 8'd0;
      press_latched  <= 1'b0;
      latched_key    <= KEY_NONE;
    end else begin
      if (cfg_we) debounce_ticks <= cfg_wdata;
      if (push) begin
        hold_count    <= hold_count_next;
        press_latched <= press_latched_next;
        latched_key   <= latched_key_next;
      end
    end
  end

endmodule

// File: rtl/core/kdte_queue.sv
// ----------------------------------------------------------------------------
// kdte_queue
// Short event queue between the debounce stage and the entry stage.
// ----------------------------------------------------------------------------
module kdte_queue
  import kdte_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  key_event_t push_event,
  input  logic       pop,
  output key_event_t head_event,
  output q_stat_t    q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  key_event_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_FULL);
  assign q_stat.empty = (count == '0);
  assign head_event   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full && !pop |-> !push)
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("event queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("event queue count out of range");

endmodule

// File: rtl/core/kdte_back.sv
// ----------------------------------------------------------------------------
// kdte_back
// Entry stage: applies key events to the entry digit, the digit store and
// the set mode sequence, and registers one result word per event.
// ----------------------------------------------------------------------------
module kdte_back
  import kdte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_stat_t    q_stat,
  input  key_event_t head_event,
  output logic       pop,
  kdte_out_if.source out_ch
);

  logic       set_mode;
  logic       set_mode_next;
  logic [2:0] cursor;
  logic [2:0] cursor_next;
  logic [3:0] digit_value;
  logic [3:0] digit_value_next;
  logic [3:0] digit_store [NUM_DIGITS];

  logic        store_we;
  logic        store_clear;
  logic        strobe;
  logic        reject;
  logic        time_ok;
  logic [20:0] time_sum;

  assign pop = ~q_stat.empty & (~out_ch.valid | out_ch.ready);

  assign time_ok = (digit_store[0] < 4'd3) && (digit_store[2] < 4'd6) &&
                   (digit_store[4] < 4'd6);

  assign time_sum = 21'(digit_store[0]) * W_HOUR_TENS
                  + 21'(digit_store[1]) * W_HOUR_ONES
                  + 21'(digit_store[2]) * W_MIN_TENS
                  + 21'(digit_store[3]) * W_MIN_ONES
                  + 21'(digit_store[4]) * W_SEC_TENS
                  + 21'(digit_store[5]);

  always_comb begin
    set_mode_next    = set_mode;
    cursor_next      = cursor;
    digit_value_next = digit_value;
    store_we         = 1'b0;
    store_clear      = 1'b0;
    strobe           = 1'b0;
    reject           = 1'b0;
    unique case (head_event)
      KEY_DOWN: begin
        digit_value_next = (digit_value == 4'd0 || digit_value > DIGIT_MAX) ?
                           DIGIT_MAX : digit_value - 4'd1;
      end
      KEY_UP: begin
        digit_value_next = (digit_value >= DIGIT_MAX) ? 4'd0 : digit_value + 4'd1;
      end
      KEY_SET: begin
        if (!set_mode) begin
          set_mode_next = 1'b1;
          cursor_next   = 3'd0;
        end else if (cursor < CURSOR_CONFIRM) begin
          store_we    = 1'b1;
          cursor_next = cursor + 3'd1;
        end else begin
          // confirm: leave set mode, then commit or reject
          set_mode_next = 1'b0;
          cursor_next   = 3'd0;
          if (time_ok) begin
            strobe           = 1'b1;
            store_clear      = 1'b1;
            digit_value_next = 4'd0;
          end else begin
            reject = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_mode    <= 1'b0;
      cursor      <= 3'd0;
      digit_value <= DIGIT_RESET;
      for (int i = 0; i < NUM_DIGITS; i++) digit_store[i] <= DIGIT_BLANK;
    end else if (pop) begin
      set_mode    <= set_mode_next;
      cursor      <= cursor_next;
      digit_value <= digit_value_next;
      if (store_clear) begin
        for (int i = 0; i < NUM_DIGITS; i++) digit_store[i] <= DIGIT_BLANK;
      end else if (store_we) begin
        digit_store[cursor] <= digit_value;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pop) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.key_event     <= head_event;
      out_ch.in_set_mode   <= set_mode_next;
      out_ch.cursor_pos    <= cursor_next;
      out_ch.entry_digit   <= digit_value_next;
      out_ch.commit_strobe <= strobe;
      out_ch.commit_time   <= strobe ? time_sum[18:0] : 19'd0;
      out_ch.reject_flag   <= reject;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CURSOR_CONFIRM)
    else $error("cursor beyond confirm position");

  a_strobe_reject_excl: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.commit_strobe && out_ch.reject_flag))
    else $error("commit and reject in the same word");

  a_commit_leaves_set: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.commit_strobe |->
      !out_ch.in_set_mode && out_ch.cursor_pos == 3'd0 && out_ch.entry_digit == 4'd0)
    else $error("commit did not return to idle entry state");

  a_cursor_outside_set: assert property (@(posedge clk) disable iff (rst)
    !set_mode |-> cursor == 3'd0)
    else $error("cursor moved outside set mode");

endmodule

// File: bench/key_debounce_time_entry_tb.sv
// ----------------------------------------------------------------------------
// key_debounce_time_entry_tb
// Drives key sample words into the debounce and time entry block and checks
// every result word. A directed table covers reset state, key priority,
// glitches shorter than the threshold and keys held past the latch point.
// Random time entry sequences with noise follow, under several debounce
// thresholds, random stalls on both channels and a long output hold-off.
// Each result is compared with a local model of the key and entry state.
// ----------------------------------------------------------------------------
module key_debounce_time_entry_tb;
  import kdte_pkg::*;

  // key word is {down_n, set_n, up_n}; a 0 bit means pressed
  localparam int B_DOWN = 2;
  localparam int B_SET  = 1;
  localparam int B_UP   = 0;

  localparam logic [2:0] KEYS_IDLE    = 3'b111;
  localparam logic [2:0] PRESS_DOWN   = 3'b011;
  localparam logic [2:0] PRESS_SET    = 3'b101;
  localparam logic [2:0] PRESS_UP     = 3'b110;
  localparam logic [2:0] PRESS_ALL    = 3'b000;
  localparam logic [2:0] PRESS_SET_UP = 3'b100;

  localparam logic [3:0] HOUR_TENS_END  = 4'd3;
  localparam logic [3:0] SIXTY_TENS_END = 4'd6;

  localparam int ITEMS_TARGET   = 1100;
  localparam int PHASE_ITEMS    = 130;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int IDLE_PCT       = 38;

  localparam int N_PLAN = 8;
  localparam logic [7:0] THR_PLAN [N_PLAN] = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd3, 8'd1, 8'd6, 8'd2};

  typedef struct packed {
    key_event_t  ev;
    logic        sm;
    logic [2:0]  cur;
    logic [3:0]  dig;
    logic        strobe;
    logic [18:0] ctime;
    logic        rej;
  } tick_result_t;

  typedef struct packed {
    logic [2:0] keys;
    logic       typed;
    key_event_t ev;
    logic       sm;
    logic [2:0] cur;
    logic [3:0] dig;
  } dir_row_t;

  // Threshold 4 after reset; typed rows give the expected state on each idle sample
  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{KEYS_IDLE,    1'b1, KEY_NONE, 1'b0, 3'd0, 4'd1},
    '{PRESS_ALL,    1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_ALL,    1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_ALL,    1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_ALL,    1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{KEYS_IDLE,    1'b1, KEY_DOWN, 1'b0, 3'd0, 4'd0},
    '{PRESS_SET_UP, 1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_SET_UP, 1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_SET_UP, 1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_SET_UP, 1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{KEYS_IDLE,    1'b1, KEY_SET,  1'b1, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{KEYS_IDLE,    1'b1, KEY_NONE, 1'b1, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_UP,     1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{KEYS_IDLE,    1'b1, KEY_UP,   1'b1, 3'd0, 4'd1},
    '{PRESS_DOWN,   1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_DOWN,   1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_DOWN,   1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_DOWN,   1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{PRESS_DOWN,   1'b0, KEY_NONE, 1'b0, 3'd0, 4'd0},
    '{KEYS_IDLE,    1'b1, KEY_DOWN, 1'b1, 3'd0, 4'd0}
  };

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  kdte_in_if  in_ch();
  kdte_out_if out_ch();

  key_debounce_time_entry dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Local copy of the key and entry state
  logic [7:0] deb_ticks;
  logic [7:0] hold_cnt;
  logic       latched;
  key_event_t held_key;
  logic       smode;
  logic [2:0] cur;
  logic [3:0] dval;
  logic [3:0] digits [NUM_DIGITS];

  tick_result_t pending_results [$];
  int  n_polled;
  int  n_errors;
  int  quiet_cycles;
  bit  idle_on;
  bit  rx_hold_req;
  int  rx_hold_left;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] hold_limit();
    return (deb_ticks == 8'd0) ? 8'd1 : deb_ticks;
  endfunction

  // Advance the local state by one key sample and return the result word
  function automatic tick_result_t poll_keys(logic [2:0] k);
    logic         dn;
    logic         st;
    logic         up;
    logic [7:0]   lim;
    logic [20:0]  sum;
    tick_result_t r;
    dn  = !k[B_DOWN];
    st  = !k[B_SET];
    up  = !k[B_UP];
    lim = hold_limit();
    r   = '0;
    if (dn || st || up) begin
      if (hold_cnt < lim) begin
        hold_cnt = hold_cnt + 8'd1;
        if (hold_cnt == lim) begin
          latched  = 1'b1;
          held_key = dn ? KEY_DOWN : (st ? KEY_SET : KEY_UP);
        end
      end
    end else begin
      hold_cnt = 8'd0;
      if (latched) begin
        latched = 1'b0;
        r.ev    = held_key;
      end
    end
    case (r.ev)
      KEY_DOWN: dval = (dval == 4'd0 || dval > DIGIT_MAX) ? DIGIT_MAX : dval - 4'd1;
      KEY_UP:   dval = (dval >= DIGIT_MAX) ? 4'd0 : dval + 4'd1;
      KEY_SET: begin
        if (!smode) begin
          smode = 1'b1;
          cur   = 3'd0;
        end else if (cur < CURSOR_CONFIRM) begin
          digits[cur] = dval;
          cur         = cur + 3'd1;
        end else begin
          smode = 1'b0;
          cur   = 3'd0;
          if (digits[0] < HOUR_TENS_END && digits[2] < SIXTY_TENS_END &&
              digits[4] < SIXTY_TENS_END) begin
            sum = 21'(digits[0]) * W_HOUR_TENS + 21'(digits[1]) * W_HOUR_ONES +
                  21'(digits[2]) * W_MIN_TENS + 21'(digits[3]) * W_MIN_ONES +
                  21'(digits[4]) * W_SEC_TENS + 21'(digits[5]);
            r.ctime  = 19'(sum);
            r.strobe = 1'b1;
            foreach (digits[i]) digits[i] = DIGIT_BLANK;
            dval = 4'd0;
          end else begin
            r.rej = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.sm  = smode;
    r.cur = cur;
    r.dig = dval;
    return r;
  endfunction

  // Offer one key word, with random gaps, and log its result once accepted
  task automatic send_keys(input logic [2:0] k, input bit use_typed,
                           input tick_result_t typed_res);
    tick_result_t r;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      {in_ch.key_down_n, in_ch.key_set_n, in_ch.key_up_n} <= 3'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.key_down_n, in_ch.key_set_n, in_ch.key_up_n} <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = poll_keys(k);
    pending_results.push_back(use_typed ? typed_res : r);
    n_polled++;
  endtask

  task automatic poll(input logic [2:0] k);
    send_keys(k, 1'b0, '0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_thr(input logic [7:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    deb_ticks = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Press one key long enough to latch (extra < 0 gives a glitch), then release
  task automatic stroke(input key_event_t key, input int extra);
    logic [2:0] pat;
    pat = KEYS_IDLE;
    case (key)
      KEY_DOWN: begin
        pat[B_DOWN] = 1'b0;
        pat[B_SET]  = ($urandom_range(3) != 0);
        pat[B_UP]   = ($urandom_range(3) != 0);
      end
      KEY_SET: begin
        pat[B_SET] = 1'b0;
        pat[B_UP]  = ($urandom_range(3) != 0);
      end
      default: pat[B_UP] = 1'b0;
    endcase
    repeat (int'(hold_limit()) + extra) poll(pat);
    repeat (1 + $urandom_range(1)) poll(KEYS_IDLE);
  endtask

  task automatic enter_time();
    logic [3:0] target [NUM_DIGITS];
    bit         bad;
    int         diff;
    int         guard;
    int         steps;
    bad = ($urandom_range(4) == 0);
    foreach (target[i]) target[i] = 4'($urandom_range(9));
    if (!bad) begin
      target[0] = 4'($urandom_range(2));
      target[2] = 4'($urandom_range(5));
      target[4] = 4'($urandom_range(5));
    end
    if (!smode) stroke(KEY_SET, $urandom_range(2));
    steps = 0;
    while (smode && cur < CURSOR_CONFIRM && steps < NUM_DIGITS + 2) begin
      guard = 0;
      while (dval != target[cur] && guard < 12) begin
        diff = (int'(target[cur]) - int'(dval) + 10) % 10;
        stroke(diff <= 5 ? KEY_UP : KEY_DOWN, $urandom_range(2));
        guard++;
      end
      stroke(KEY_SET, $urandom_range(2));
      steps++;
    end
    // confirm
    if (smode) stroke(KEY_SET, $urandom_range(2));
  endtask

  task automatic noise();
    repeat (1 + $urandom_range(5)) poll(3'($urandom));
    poll(KEYS_IDLE);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result word with nothing expected, expected none, actual event %0d",
                 $time, out_ch.key_event);
      end else begin
        want = pending_results.pop_front();
        check_field("key_event", 32'(want.ev), 32'(out_ch.key_event));
        check_field("in_set_mode", 32'(want.sm), 32'(out_ch.in_set_mode));
        check_field("cursor_pos", 32'(want.cur), 32'(out_ch.cursor_pos));
        check_field("entry_digit", 32'(want.dig), 32'(out_ch.entry_digit));
        check_field("commit_strobe", 32'(want.strobe), 32'(out_ch.commit_strobe));
        check_field("commit_time", 32'(want.ctime), 32'(out_ch.commit_time));
        check_field("reject_flag", 32'(want.rej), 32'(out_ch.reject_flag));
      end
    end
  end

  // Output side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int           phase;
    int           start;
    int           sel;
    bit           paused;
    tick_result_t row_res;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = 8'd0;
    in_ch.valid      = 1'b0;
    in_ch.key_down_n = 1'b1;
    in_ch.key_set_n  = 1'b1;
    in_ch.key_up_n   = 1'b1;
    out_ch.ready     = 1'b0;
    n_polled         = 0;
    n_errors         = 0;
    quiet_cycles     = 0;
    idle_on          = 1'b1;
    rx_hold_req      = 1'b0;
    rx_hold_left     = 0;
    deb_ticks        = DEBOUNCE_RESET;
    hold_cnt         = 8'd0;
    latched          = 1'b0;
    held_key         = KEY_NONE;
    smode            = 1'b0;
    cur              = 3'd0;
    dval             = DIGIT_RESET;
    foreach (digits[i]) digits[i] = DIGIT_BLANK;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      row_res = '{DIR_TAB[i].ev, DIR_TAB[i].sm, DIR_TAB[i].cur, DIR_TAB[i].dig,
                  1'b0, 19'd0, 1'b0};
      send_keys(DIR_TAB[i].keys, DIR_TAB[i].typed, row_res);
    end

    // Lower the threshold under a hold already past it: no latch this hold
    write_thr(8'd8);
    repeat (5) poll(PRESS_DOWN);
    write_thr(8'd2);
    repeat (3) poll(PRESS_DOWN);
    poll(KEYS_IDLE);

    for (phase = 0; n_polled < ITEMS_TARGET; phase++) begin
      write_thr(phase < N_PLAN ? THR_PLAN[phase] : 8'($urandom_range(1, 4)));
      idle_on = (phase != 2);
      // block the output while the input keeps offering words
      if (phase == 1) rx_hold_req = 1'b1;
      if (deb_ticks == 8'd255) begin
        stroke(KEY_UP, 1);
        continue;
      end
      start  = n_polled;
      paused = 1'b0;
      while (n_polled - start < PHASE_ITEMS && n_polled < ITEMS_TARGET) begin
        if (phase == 4 && !paused && n_polled - start > PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        sel = $urandom_range(99);
        if (sel < 60) begin
          enter_time();
        end else if (sel < 85) begin
          stroke(key_event_t'($urandom_range(1, 3)),
                 (hold_limit() > 8'd1 && $urandom_range(3) == 0) ? -1 : $urandom_range(2));
        end else begin
          noise();
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kdte_pkg.sv
rtl/core/kdte_if.sv
rtl/core/kdte_front.sv
rtl/core/kdte_queue.sv
rtl/core/kdte_back.sv
rtl/core/key_debounce_time_entry.sv
bench/key_debounce_time_entry_tb.sv
